### rtl/core/sppi_pkg.sv
// Package for the split-phase power PI controller.
// Holds field widths, reset values, register indexes and the command struct.
// Used by sppi_ctrl, sppi_dp and split_phase_power_pi.
package sppi_pkg;

    localparam int DATA_W          = 32;
    localparam int ERR_W           = DATA_W + 1;
    localparam int GAIN_W          = 31;
    localparam int INTEG_W         = 48;
    localparam int FRAC_W          = 16;
    localparam int ACC_W           = 64;
    localparam int PHASE_W         = 2;
    localparam int CFG_IDX_W       = 3;
    localparam int PHASE_COUNT_DEF = 3;

    localparam logic [GAIN_W-1:0]        KP_RESET  = GAIN_W'(65536);
    localparam logic [GAIN_W-1:0]        KI_RESET  = '0;
    localparam logic signed [DATA_W-1:0] MAX_RESET = DATA_W'(65536);
    localparam logic signed [DATA_W-1:0] MIN_RESET = -DATA_W'(65536);

    // Reciprocal of three for operands below 2^33: floor(n/3) = (n * DIV3_MUL) >> DIV3_SHIFT.
    localparam int               DIV3_SHIFT = 34;
    localparam logic [ERR_W-1:0] DIV3_MUL   = 33'h155555556;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_ACTIVE    = 3'd0,
        CFG_KI_ACTIVE    = 3'd1,
        CFG_MAX_ACTIVE   = 3'd2,
        CFG_MIN_ACTIVE   = 3'd3,
        CFG_KP_REACTIVE  = 3'd4,
        CFG_KI_REACTIVE  = 3'd5,
        CFG_MAX_REACTIVE = 3'd6,
        CFG_MIN_REACTIVE = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MUL_KP = 2'd0,
        MUL_HI = 2'd1,
        MUL_LO = 2'd2
    } mul_op_t;

    typedef struct packed {
        logic    accept;
        logic    loop_q;
        logic    mul_en;
        mul_op_t mul_op;
        logic    clamp_en;
        logic    div_p_en;
        logic    load_out;
    } dp_cmd_t;

endpackage

### rtl/core/sppi_ctrl.sv
// Sequencer for the split-phase power PI controller.
// Steps the datapath through both loops of one item and owns the handshake state.
// Depends on sppi_pkg.
module sppi_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output sppi_pkg::dp_cmd_t cmd
);
    import sppi_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_KP_P    = 10'b0000000010,
        S_HI_P    = 10'b0000000100,
        S_LO_P    = 10'b0000001000,
        S_CLAMP_P = 10'b0000010000,
        S_KP_Q    = 10'b0000100000,
        S_HI_Q    = 10'b0001000000,
        S_LO_Q    = 10'b0010000000,
        S_CLAMP_Q = 10'b0100000000,
        S_DIV_Q   = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_KP_P;
                end
            end
            S_KP_P:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_KP;
                state_next = S_HI_P;
            end
            S_HI_P:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_HI;
                state_next = S_LO_P;
            end
            S_LO_P:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_LO;
                state_next = S_CLAMP_P;
            end
            S_CLAMP_P:
            begin
                cmd.clamp_en = 1'b1;
                state_next   = S_KP_Q;
            end
            S_KP_Q:
            begin
                cmd.loop_q   = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_op   = MUL_KP;
                cmd.div_p_en = 1'b1;
                state_next   = S_HI_Q;
            end
            S_HI_Q:
            begin
                cmd.loop_q = 1'b1;
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_HI;
                state_next = S_LO_Q;
            end
            S_LO_Q:
            begin
                cmd.loop_q = 1'b1;
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_LO;
                state_next = S_CLAMP_Q;
            end
            S_CLAMP_Q:
            begin
                cmd.loop_q   = 1'b1;
                cmd.clamp_en = 1'b1;
                state_next   = S_DIV_Q;
            end
            S_DIV_Q:
            begin
                cmd.loop_q = 1'b1;
                if (!(out_valid_reg && out_stall))
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid_reg && out_stall))
        else $error("result loaded over a pending transfer");
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == S_KP_P))
        else $error("accepted item did not start the active loop");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after a transfer");
`endif

endmodule

### rtl/core/sppi_dp.sv
// Datapath of the split-phase power PI controller.
// Holds configuration, per-phase integrators, the shared gain multiplier and the 2/3 scaler.
// Depends on sppi_pkg; driven by sppi_ctrl.
module sppi_dp #(
    parameter int PHASE_COUNT = sppi_pkg::PHASE_COUNT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sppi_pkg::dp_cmd_t                    cmd,
    input  logic                                 cfg_wr_en,
    input  logic [sppi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sppi_pkg::DATA_W-1:0]          cfg_wr_data,
    input  logic [sppi_pkg::PHASE_W-1:0]         phase_index,
    input  logic signed [sppi_pkg::DATA_W-1:0]   ref_active,
    input  logic signed [sppi_pkg::DATA_W-1:0]   ref_reactive,
    input  logic signed [sppi_pkg::DATA_W-1:0]   fdb_active,
    input  logic signed [sppi_pkg::DATA_W-1:0]   fdb_reactive,
    input  logic                                 clear_all,
    output logic [sppi_pkg::PHASE_W-1:0]         out_phase,
    output logic signed [sppi_pkg::DATA_W-1:0]   current_d,
    output logic signed [sppi_pkg::DATA_W-1:0]   current_q,
    output logic                                 sat_active,
    output logic                                 sat_reactive
);
    import sppi_pkg::*;

    localparam int IDX_W  = (PHASE_COUNT > 1) ? $clog2(PHASE_COUNT) : 1;
    localparam int PROD_W = GAIN_W + 1 + ERR_W;
    localparam int EXT_W  = ACC_W - DATA_W;
    localparam int DPROD_W = 2 * ERR_W;

    logic [GAIN_W-1:0]        kp_p_reg;
    logic [GAIN_W-1:0]        ki_p_reg;
    logic signed [DATA_W-1:0] max_p_reg;
    logic signed [DATA_W-1:0] min_p_reg;
    logic [GAIN_W-1:0]        kp_q_reg;
    logic [GAIN_W-1:0]        ki_q_reg;
    logic signed [DATA_W-1:0] max_q_reg;
    logic signed [DATA_W-1:0] min_q_reg;

    logic signed [INTEG_W-1:0] integ_p_reg [PHASE_COUNT];
    logic signed [INTEG_W-1:0] integ_q_reg [PHASE_COUNT];

    logic [PHASE_W-1:0]        phase_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic                      phase_ok_reg;
    logic signed [ERR_W-1:0]   err_p_reg;
    logic signed [ERR_W-1:0]   err_q_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [ERR_W-1:0]          n_reg;
    logic                      neg_reg;
    logic                      sat_p_reg;
    logic                      sat_q_reg;
    logic signed [DATA_W-1:0]  id_work_reg;

    logic [PHASE_W-1:0]        out_phase_reg;
    logic signed [DATA_W-1:0]  current_d_reg;
    logic signed [DATA_W-1:0]  current_q_reg;
    logic                      sat_active_reg;
    logic                      sat_reactive_reg;

    logic signed [ERR_W-1:0]   err_sel;
    logic signed [INTEG_W-1:0] integ_rd;
    logic [GAIN_W-1:0]         gain_sel;
    logic signed [ERR_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  prod_shift;
    logic signed [ACC_W-1:0]   addend;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [DATA_W-1:0]  max_sel;
    logic signed [DATA_W-1:0]  min_sel;
    logic                      above;
    logic                      below;
    logic                      clamp_sat;
    logic signed [DATA_W-1:0]  u_clamp;
    logic [DATA_W-1:0]         u_abs;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] integ_new;
    logic [DPROD_W-1:0]        dprod;
    logic [DATA_W-1:0]         div_r;
    logic signed [DATA_W-1:0]  div_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_p_reg  <= KP_RESET;
            ki_p_reg  <= KI_RESET;
            max_p_reg <= MAX_RESET;
            min_p_reg <= MIN_RESET;
            kp_q_reg  <= KP_RESET;
            ki_q_reg  <= KI_RESET;
            max_q_reg <= MAX_RESET;
            min_q_reg <= MIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_KP_ACTIVE:    kp_p_reg  <= cfg_wr_data[GAIN_W-1:0];
                CFG_KI_ACTIVE:    ki_p_reg  <= cfg_wr_data[GAIN_W-1:0];
                CFG_MAX_ACTIVE:   max_p_reg <= cfg_wr_data;
                CFG_MIN_ACTIVE:   min_p_reg <= cfg_wr_data;
                CFG_KP_REACTIVE:  kp_q_reg  <= cfg_wr_data[GAIN_W-1:0];
                CFG_KI_REACTIVE:  ki_q_reg  <= cfg_wr_data[GAIN_W-1:0];
                CFG_MAX_REACTIVE: max_q_reg <= cfg_wr_data;
                CFG_MIN_REACTIVE: min_q_reg <= cfg_wr_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            phase_reg    <= phase_index;
            idx_reg      <= IDX_W'(phase_index);
            phase_ok_reg <= (32'(phase_index) < PHASE_COUNT);
            err_p_reg    <= $signed({ref_active[DATA_W-1], ref_active})
                          - $signed({fdb_active[DATA_W-1], fdb_active});
            err_q_reg    <= $signed({ref_reactive[DATA_W-1], ref_reactive})
                          - $signed({fdb_reactive[DATA_W-1], fdb_reactive});
        end
    end

    assign err_sel  = cmd.loop_q ? err_q_reg : err_p_reg;
    assign integ_rd = !phase_ok_reg ? '0
                    : (cmd.loop_q ? integ_q_reg[idx_reg] : integ_p_reg[idx_reg]);

    // The integral term is split at the binary point so each product stays
    // within 32 by 33 bits: floor(ki*integ) = ki*hi + floor(ki*lo).
    always_comb
    begin
        if (cmd.mul_op == MUL_KP)
        begin
            gain_sel = cmd.loop_q ? kp_q_reg : kp_p_reg;
        end
        else
        begin
            gain_sel = cmd.loop_q ? ki_q_reg : ki_p_reg;
        end
        case (cmd.mul_op)
            MUL_KP: mul_b = err_sel;
            MUL_HI: mul_b = {{(ERR_W - (INTEG_W - FRAC_W)){integ_rd[INTEG_W-1]}},
                             integ_rd[INTEG_W-1:FRAC_W]};
            MUL_LO: mul_b = {{(ERR_W - FRAC_W){1'b0}}, integ_rd[FRAC_W-1:0]};
            default: mul_b = '0;
        endcase
    end

    assign prod       = $signed({1'b0, gain_sel}) * mul_b;
    assign prod_shift = prod >>> FRAC_W;
    assign addend     = (cmd.mul_op == MUL_HI) ? prod[ACC_W-1:0] : prod_shift[ACC_W-1:0];
    assign acc_next   = ((cmd.mul_op == MUL_KP) ? '0 : acc_reg) + addend;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign max_sel   = cmd.loop_q ? max_q_reg : max_p_reg;
    assign min_sel   = cmd.loop_q ? min_q_reg : min_p_reg;
    assign above     = acc_reg > $signed({{EXT_W{max_sel[DATA_W-1]}}, max_sel});
    assign below     = acc_reg < $signed({{EXT_W{min_sel[DATA_W-1]}}, min_sel});
    assign clamp_sat = above || below;
    assign u_clamp   = above ? max_sel : (below ? min_sel : acc_reg[DATA_W-1:0]);
    assign u_abs     = u_clamp[DATA_W-1] ? (-u_clamp) : u_clamp;

    assign integ_sum = $signed({integ_rd[INTEG_W-1], integ_rd})
                     + $signed({{(INTEG_W + 1 - ERR_W){err_sel[ERR_W-1]}}, err_sel});
    assign integ_new = (integ_sum[INTEG_W] != integ_sum[INTEG_W-1])
                     ? {integ_sum[INTEG_W], {(INTEG_W - 1){~integ_sum[INTEG_W]}}}
                     : integ_sum[INTEG_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PHASE_COUNT; i++)
            begin
                integ_p_reg[i] <= '0;
                integ_q_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.accept && clear_all)
            begin
                for (int i = 0; i < PHASE_COUNT; i++)
                begin
                    integ_p_reg[i] <= '0;
                    integ_q_reg[i] <= '0;
                end
            end
            if (cmd.clamp_en && phase_ok_reg && !clamp_sat)
            begin
                if (cmd.loop_q)
                begin
                    integ_q_reg[idx_reg] <= integ_new;
                end
                else
                begin
                    integ_p_reg[idx_reg] <= integ_new;
                end
            end
        end
    end

    // The reactive reference carries the opposite sign, so its negate flag is inverted.
    always_ff @(posedge clk)
    begin
        if (cmd.clamp_en)
        begin
            n_reg   <= {u_abs, 1'b1};
            neg_reg <= cmd.loop_q ? !u_clamp[DATA_W-1] : u_clamp[DATA_W-1];
            if (cmd.loop_q)
            begin
                sat_q_reg <= clamp_sat && phase_ok_reg;
            end
            else
            begin
                sat_p_reg <= clamp_sat && phase_ok_reg;
            end
        end
    end

    assign dprod   = DPROD_W'(n_reg) * DPROD_W'(DIV3_MUL);
    assign div_r   = dprod[DIV3_SHIFT +: DATA_W];
    assign div_out = neg_reg ? (-div_r) : div_r;

    always_ff @(posedge clk)
    begin
        if (cmd.div_p_en)
        begin
            id_work_reg <= div_out;
        end
        if (cmd.load_out)
        begin
            out_phase_reg    <= phase_reg;
            current_d_reg    <= phase_ok_reg ? id_work_reg : '0;
            current_q_reg    <= phase_ok_reg ? div_out : '0;
            sat_active_reg   <= sat_p_reg;
            sat_reactive_reg <= sat_q_reg;
        end
    end

    assign out_phase    = out_phase_reg;
    assign current_d    = current_d_reg;
    assign current_q    = current_q_reg;
    assign sat_active   = sat_active_reg;
    assign sat_reactive = sat_reactive_reg;

`ifndef SYNTHESIS
    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && clear_all) |=> (integ_p_reg[0] == '0) && (integ_q_reg[0] == '0))
        else $error("integrators not cleared");
    a_bad_phase_out: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && !phase_ok_reg) |=>
            (current_d == '0) && (current_q == '0) && !sat_active && !sat_reactive)
        else $error("out-of-range phase gave a nonzero result");
    a_bad_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.clamp_en && !phase_ok_reg) |=>
            $stable(integ_p_reg[0]) && $stable(integ_q_reg[0]))
        else $error("out-of-range phase changed an integrator");
`endif

endmodule

### rtl/core/split_phase_power_pi.sv
// Per-phase active and reactive power PI controller with clamp and conditional integration.
// Top level: joins the sequencer sppi_ctrl and the datapath sppi_dp.
// Depends on sppi_pkg.
//
// Usage:
// An input transfer carries one phase's P and Q references and feedback. It is taken
// when in_valid is high and in_stall is low. Each transfer yields exactly one result
// transfer with the current references and the saturation flags of both loops.
// One shared gain multiplier forms the proportional, integral-high and integral-low
// products of each loop in turn, plus a clamp step per loop and a final step that
// loads the result. The sequencer takes a new item only in its idle state, so the
// input stays stalled until the item before has reached the output register.
// The result sits in an output register, so the next item is taken while a result
// still waits. If out_stall holds that result until the next one is done, the
// sequencer waits in its last step and the input stays stalled.
// Reset clears the integrators of every phase, restores the default gains and clamps,
// and drops out_valid. Configuration writes take effect at once; the user must make
// them only while the block is idle, as the block itself does not enforce this.
module split_phase_power_pi #(
    parameter int PHASE_COUNT = sppi_pkg::PHASE_COUNT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [sppi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sppi_pkg::DATA_W-1:0]          cfg_wr_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [sppi_pkg::PHASE_W-1:0]         phase_index,
    input  logic signed [sppi_pkg::DATA_W-1:0]   ref_active,
    input  logic signed [sppi_pkg::DATA_W-1:0]   ref_reactive,
    input  logic signed [sppi_pkg::DATA_W-1:0]   fdb_active,
    input  logic signed [sppi_pkg::DATA_W-1:0]   fdb_reactive,
    input  logic                                 clear_all,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [sppi_pkg::PHASE_W-1:0]         out_phase,
    output logic signed [sppi_pkg::DATA_W-1:0]   current_d,
    output logic signed [sppi_pkg::DATA_W-1:0]   current_q,
    output logic                                 sat_active,
    output logic                                 sat_reactive
);
    import sppi_pkg::*;

    dp_cmd_t cmd;

    sppi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    sppi_dp #(
        .PHASE_COUNT (PHASE_COUNT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .phase_index  (phase_index),
        .ref_active   (ref_active),
        .ref_reactive (ref_reactive),
        .fdb_active   (fdb_active),
        .fdb_reactive (fdb_reactive),
        .clear_all    (clear_all),
        .out_phase    (out_phase),
        .current_d    (current_d),
        .current_q    (current_q),
        .sat_active   (sat_active),
        .sat_reactive (sat_reactive)
    );

endmodule
